@@ rtl/mndr_pkg.sv @@
// ----------------------------------------------------------------------------
// mndr_pkg
// Types and constants shared by the MIDI note delay router.
// ----------------------------------------------------------------------------
package mndr_pkg;

   localparam int QUEUE_DEPTH_DEF = 64;

   localparam int DELAY_W = 20;
   localparam int MASK_W  = 64;
   localparam int LEN_W   = 16;
   localparam int REM_W   = 21;
   localparam int MSG_W   = 22;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   // opcodes
   localparam logic OP_BLOCK = 1'b0;
   localparam logic OP_EVENT = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LISTED_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LISTED_HIGH = 2'd2;

   // note on / note off recognition
   localparam logic [7:0] NOTE_STATUS_MASK  = 8'hE0;
   localparam logic [7:0] NOTE_STATUS_MATCH = 8'h80;

   typedef struct packed {
      logic             opcode;
      logic [LEN_W-1:0] block_samples;
      logic [7:0]       status_byte;
      logic [6:0]       data_one;
      logic [6:0]       data_two;
      logic [LEN_W-1:0] sample_pos;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_status;
      logic [6:0]       out_data_one;
      logic [6:0]       out_data_two;
      logic [LEN_W-1:0] out_pos;
      logic             dropped;
      logic             last;
   } rsp_type;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_FL_RD  = 7'b0000010,
      ST_FL_CHK = 7'b0000100,
      ST_FL_FIN = 7'b0001000,
      ST_EV_CHK = 7'b0010000,
      ST_EV_SCN = 7'b0100000,
      ST_EV_OUT = 7'b1000000
   } state_type;

endpackage

@@ rtl/midi_note_delay_router.sv @@
// ----------------------------------------------------------------------------
// midi_note_delay_router
// Timed MIDI router: delays unlisted note on/off words through a note queue
// and releases them at block starts.
// ----------------------------------------------------------------------------
// One item is handled at a time; req_stall is high after acceptance until the
// item is done, with its last result, if any, placed in the output register.
// A block start walks every queue slot through the single-port note memory:
// ST_FL_RD skips a free slot, an occupied one is read and then checked in
// ST_FL_CHK, and ST_FL_FIN ends the walk. An event passes ST_EV_CHK and then
// ST_EV_OUT when it yields a result at once; when it is queued, ST_EV_SCN
// searches the slots one by one for a free entry. A zero-length block start
// changes nothing. Results are held in one output register; a stalled output
// holds the walk until the register frees up.
module midi_note_delay_router #(
   parameter int QUEUE_DEPTH = mndr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mndr_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mndr_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [mndr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mndr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
   localparam int REM_W = mndr_pkg::REM_W;
   localparam int MSG_W = mndr_pkg::MSG_W;
   localparam int LEN_W = mndr_pkg::LEN_W;
   localparam int ENT_W = REM_W + MSG_W;

   // configuration
   logic [mndr_pkg::DELAY_W-1:0] delay_ff;
   logic [mndr_pkg::MASK_W-1:0]  listed_lo_ff;
   logic [mndr_pkg::MASK_W-1:0]  listed_hi_ff;

   // control and working registers
   mndr_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [LEN_W-1:0]   blk_len_ff, blk_len_in;
   logic [MSG_W-1:0]   ev_msg_ff, ev_msg_in;
   logic [LEN_W-1:0]   ev_pos_ff, ev_pos_in;
   logic               ev_delay_ff, ev_delay_in;
   logic [REM_W-1:0]   ev_emit_ff, ev_emit_in;
   logic               held_valid_ff, held_valid_in;
   logic [MSG_W-1:0]   held_msg_ff, held_msg_in;
   logic [LEN_W-1:0]   held_pos_ff, held_pos_in;
   logic               held_drop_ff, held_drop_in;
   logic               rsp_valid_ff, rsp_valid_in;
   mndr_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic               valid_ff [QUEUE_DEPTH];
   logic               valid_set, valid_clr;

   // note memory: {remaining delay, message}
   logic [ENT_W-1:0]   mem [QUEUE_DEPTH];
   logic [ENT_W-1:0]   rd_ff;
   logic               mem_we;
   logic [ENT_W-1:0]   mem_wdata;

   logic               req_acc;
   logic               out_free;
   logic               out_load;
   logic               out_last;
   logic [REM_W-1:0]   sub_a;
   logic [REM_W:0]     sub_res;
   logic               sub_lt;
   logic [REM_W-1:0]   rd_rem;
   logic [MSG_W-1:0]   rd_msg;
   logic [127:0]       listed_all;
   logic               is_note;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != mndr_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rd_rem = rd_ff[ENT_W-1:MSG_W];
   assign rd_msg = rd_ff[MSG_W-1:0];

   assign listed_all = {listed_hi_ff, listed_lo_ff};
   assign is_note = (req_data.status_byte & mndr_pkg::NOTE_STATUS_MASK)
                    == mndr_pkg::NOTE_STATUS_MATCH;

   // shared subtract unit: compare against block length and form the remainder
   assign sub_a   = (state_ff == mndr_pkg::ST_EV_CHK) ? ev_emit_ff : rd_rem;
   assign sub_res = {1'b0, sub_a} - {{(REM_W + 1 - LEN_W){1'b0}}, blk_len_ff};
   assign sub_lt  = sub_res[REM_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff     <= '0;
         listed_lo_ff <= '0;
         listed_hi_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            mndr_pkg::CSR_DELAY:       delay_ff     <= csr_wdata[mndr_pkg::DELAY_W-1:0];
            mndr_pkg::CSR_LISTED_LOW:  listed_lo_ff <= csr_wdata;
            mndr_pkg::CSR_LISTED_HIGH: listed_hi_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      blk_len_in    = blk_len_ff;
      ev_msg_in     = ev_msg_ff;
      ev_pos_in     = ev_pos_ff;
      ev_delay_in   = ev_delay_ff;
      ev_emit_in    = ev_emit_ff;
      held_valid_in = held_valid_ff;
      held_msg_in   = held_msg_ff;
      held_pos_in   = held_pos_ff;
      held_drop_in  = held_drop_ff;
      valid_set     = 1'b0;
      valid_clr     = 1'b0;
      mem_we        = 1'b0;
      mem_wdata     = {ev_emit_ff, ev_msg_ff};
      out_load      = 1'b0;
      out_last      = 1'b1;

      case (state_ff)
         mndr_pkg::ST_IDLE: begin
            if (req_acc) begin
               idx_in = '0;
               if (req_data.opcode == mndr_pkg::OP_BLOCK) begin
                  if (req_data.block_samples != '0) begin
                     blk_len_in = req_data.block_samples;
                     state_in   = mndr_pkg::ST_FL_RD;
                  end
               end else begin
                  ev_msg_in   = {req_data.status_byte, req_data.data_one, req_data.data_two};
                  ev_pos_in   = req_data.sample_pos;
                  ev_delay_in = is_note && !listed_all[req_data.data_one];
                  ev_emit_in  = {{(REM_W - LEN_W){1'b0}}, req_data.sample_pos}
                              + {{(REM_W - mndr_pkg::DELAY_W){1'b0}}, delay_ff};
                  state_in    = mndr_pkg::ST_EV_CHK;
               end
            end
         end

         mndr_pkg::ST_FL_RD: begin
            if (valid_ff[idx_ff]) begin
               state_in = mndr_pkg::ST_FL_CHK;
            end else if (idx_ff == LAST_IDX) begin
               state_in = mndr_pkg::ST_FL_FIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         mndr_pkg::ST_FL_CHK: begin
            if (!sub_lt) begin
               mem_we    = 1'b1;
               mem_wdata = {sub_res[REM_W-1:0], rd_msg};
            end
            // a due note waits in the hold register until the next one shows it
            // was not the final result
            if (!sub_lt || !held_valid_ff || out_free) begin
               if (sub_lt) begin
                  valid_clr     = 1'b1;
                  out_load      = held_valid_ff;
                  out_last      = 1'b0;
                  held_valid_in = 1'b1;
                  held_msg_in   = rd_msg;
                  held_pos_in   = rd_rem[LEN_W-1:0];
                  held_drop_in  = 1'b0;
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = mndr_pkg::ST_FL_FIN;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = mndr_pkg::ST_FL_RD;
               end
            end
         end

         mndr_pkg::ST_FL_FIN: begin
            if (!held_valid_ff) begin
               state_in = mndr_pkg::ST_IDLE;
            end else if (out_free) begin
               out_load      = 1'b1;
               held_valid_in = 1'b0;
               state_in      = mndr_pkg::ST_IDLE;
            end
         end

         mndr_pkg::ST_EV_CHK: begin
            held_msg_in  = ev_msg_ff;
            held_drop_in = 1'b0;
            if (!ev_delay_ff) begin
               held_valid_in = 1'b1;
               held_pos_in   = ev_pos_ff;
               state_in      = mndr_pkg::ST_EV_OUT;
            end else if (sub_lt) begin
               held_valid_in = 1'b1;
               held_pos_in   = ev_emit_ff[LEN_W-1:0];
               state_in      = mndr_pkg::ST_EV_OUT;
            end else begin
               ev_emit_in = sub_res[REM_W-1:0];
               state_in   = mndr_pkg::ST_EV_SCN;
            end
         end

         mndr_pkg::ST_EV_SCN: begin
            if (!valid_ff[idx_ff]) begin
               mem_we    = 1'b1;
               valid_set = 1'b1;
               state_in  = mndr_pkg::ST_IDLE;
            end else if (idx_ff == LAST_IDX) begin
               // queue full: drop and flag
               held_valid_in = 1'b1;
               held_msg_in   = ev_msg_ff;
               held_pos_in   = '0;
               held_drop_in  = 1'b1;
               state_in      = mndr_pkg::ST_EV_OUT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         mndr_pkg::ST_EV_OUT: begin
            if (out_free) begin
               out_load      = 1'b1;
               held_valid_in = 1'b0;
               state_in      = mndr_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mndr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.out_status   = held_msg_ff[MSG_W-1:14];
         rsp_data_in.out_data_one = held_msg_ff[13:7];
         rsp_data_in.out_data_two = held_msg_ff[6:0];
         rsp_data_in.out_pos      = held_pos_ff;
         rsp_data_in.dropped      = held_drop_ff;
         rsp_data_in.last         = out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mndr_pkg::ST_IDLE;
         idx_ff        <= '0;
         blk_len_ff    <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         blk_len_ff    <= blk_len_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_msg_ff    <= ev_msg_in;
      ev_pos_ff    <= ev_pos_in;
      ev_delay_ff  <= ev_delay_in;
      ev_emit_ff   <= ev_emit_in;
      held_msg_ff  <= held_msg_in;
      held_pos_ff  <= held_pos_in;
      held_drop_ff <= held_drop_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (valid_set) begin
         valid_ff[idx_ff] <= 1'b1;
      end else if (valid_clr) begin
         valid_ff[idx_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[idx_ff] <= mem_wdata;
      end
      rd_ff <= mem[idx_ff];
   end

   // the hold register is empty whenever the block can take a new word
   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == mndr_pkg::ST_IDLE |-> !held_valid_ff)
      else $error("hold register occupied while idle");

   a_zero_block: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_data.opcode == mndr_pkg::OP_BLOCK && req_data.block_samples == '0
      |=> state_ff == mndr_pkg::ST_IDLE)
      else $error("zero-length block start not ignored");

   a_event_path: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_data.opcode == mndr_pkg::OP_EVENT |=> state_ff == mndr_pkg::ST_EV_CHK)
      else $error("event word took the wrong path");

   a_drop_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.dropped |-> rsp_data_ff.out_pos == '0 && rsp_data_ff.last)
      else $error("malformed drop result");

   a_flush_not_last: assert property (@(posedge clock) disable iff (reset)
      out_load && state_ff == mndr_pkg::ST_FL_CHK |-> held_valid_in)
      else $error("flush pushed a result without keeping a successor");

endmodule
